>>> rtl/mcb_pkg.sv
// shared types, codes and constants for the microcoded byte cpu datapath step
package mcb_pkg;

  localparam int unsigned NUM_WR_REGS = 22;
  localparam int unsigned NUM_REGS = 32;
  localparam int unsigned IN_TDATA_W = 72;
  localparam int unsigned OUT_TDATA_W = 64;

  localparam logic [15:0] WORD_MASK = 16'hFFFE;

  localparam logic [7:0] FIXED_REGS [10] = '{
    8'h00, 8'h01, 8'h02, 8'h03, 8'h04, 8'h08, 8'hF0, 8'hF6, 8'hFE, 8'hFF
  };

  // alu function codes
  localparam logic [4:0] FN_A    = 5'd0;
  localparam logic [4:0] FN_ADD  = 5'd1;
  localparam logic [4:0] FN_ADDC = 5'd2;
  localparam logic [4:0] FN_SUB  = 5'd3;
  localparam logic [4:0] FN_SUBC = 5'd4;
  localparam logic [4:0] FN_AND  = 5'd5;
  localparam logic [4:0] FN_NAND = 5'd6;
  localparam logic [4:0] FN_OR   = 5'd7;
  localparam logic [4:0] FN_NOR  = 5'd8;
  localparam logic [4:0] FN_XOR  = 5'd9;
  localparam logic [4:0] FN_NOTA = 5'd10;
  localparam logic [4:0] FN_ASL  = 5'd11;
  localparam logic [4:0] FN_ROL  = 5'd12;
  localparam logic [4:0] FN_ASR  = 5'd13;
  localparam logic [4:0] FN_ROR  = 5'd14;
  localparam logic [4:0] FN_NZVC = 5'd15;

  // two-bit mux selects
  localparam logic [1:0] MUX_SEL0 = 2'd0;
  localparam logic [1:0] MUX_SEL1 = 2'd1;

  // clock enable bit positions
  localparam int unsigned CK_MAR  = 0;
  localparam int unsigned CK_LOAD = 1;
  localparam int unsigned CK_MDRE = 2;
  localparam int unsigned CK_MDRO = 3;
  localparam int unsigned CK_N    = 4;
  localparam int unsigned CK_Z    = 5;
  localparam int unsigned CK_V    = 6;
  localparam int unsigned CK_C    = 7;
  localparam int unsigned CK_S    = 8;

  // flag bit positions
  localparam int unsigned FL_C = 0;
  localparam int unsigned FL_V = 1;
  localparam int unsigned FL_Z = 2;
  localparam int unsigned FL_N = 3;
  localparam int unsigned FL_S = 4;

  typedef enum logic [2:0] {
    PH_NONE     = 3'd0,
    PH_RD_WAIT1 = 3'd1,
    PH_RD_WAIT2 = 3'd2,
    PH_RD_READY = 3'd3,
    PH_WR_WAIT1 = 3'd4,
    PH_WR_WAIT2 = 3'd5,
    PH_WR_READY = 3'd6
  } phase_t;

  typedef enum logic [3:0] {
    ERR_NONE      = 4'd0,
    ERR_MAR       = 4'd1,
    ERR_LOAD_DEST = 4'd2,
    ERR_LOAD_C    = 4'd3,
    ERR_MDRE_MEM  = 4'd4,
    ERR_MDRE_C    = 4'd5,
    ERR_MDRE_MUX  = 4'd6,
    ERR_MDRO_MEM  = 4'd7,
    ERR_MDRO_C    = 4'd8,
    ERR_MDRO_MUX  = 4'd9,
    ERR_FLAG      = 4'd10
  } err_t;

  typedef struct packed {
    logic [5:0]  a_bus_select;
    logic [5:0]  b_bus_select;
    logic [5:0]  c_dest_select;
    logic [4:0]  alu_function;
    logic [15:0] mux_selects;
    logic [1:0]  mem_control;
    logic [8:0]  clock_enables;
    logic [7:0]  mem_even_byte;
    logic [7:0]  mem_odd_byte;
  } item_t;

  typedef struct packed {
    logic        mem_write_strobe;
    logic [15:0] mem_write_address;
    logic [15:0] mem_write_word;
    logic [15:0] mar_word_address;
    logic [2:0]  bus_phase;
    logic [4:0]  status_flags;
    logic [3:0]  error_code;
  } result_t;

  typedef struct packed {
    logic       en;
    logic [4:0] addr;
    logic [7:0] data;
  } reg_wr_t;

endpackage

>>> rtl/microcoded_byte_cpu_datapath_step_unit.sv
// top level: beat registers around one microinstruction step of the byte cpu datapath
//
//  channel | direction | tdata bits | fields
//  in_     | slave     | 72         | a,b,c selects, alu fn, muxes, mem ctl, clocks, bytes
//  out_    | master    | 64         | write strobe/addr/word, mar, phase, flags, error
//
//  one microinstruction per clock unless the output stalls: a beat enters the input
//  register, the step logic between it and the result register reads the bank and
//  updates mar, mdr, flags and bus phase as the result is registered
//  bank reads are registered at input acceptance, with write-through from the step
//  reset clears beat valids, bus phase, mar, mdr, flags and bank valid bits
//  a stalled output holds one result and one beat in the input register
module microcoded_byte_cpu_datapath_step_unit
  import mcb_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  // a_bus_select[5:0], b_bus_select[11:6], c_dest_select[17:12], alu_function[22:18],
  // mux_selects[38:23], mem_control[40:39], clock_enables[49:41],
  // mem_even_byte[57:50], mem_odd_byte[65:58], zero fill above
  input  logic [IN_TDATA_W-1:0]  in_tdata,
  output logic                   out_tvalid,
  input  logic                   out_tready,
  // mem_write_strobe[0], mem_write_address[16:1], mem_write_word[32:17],
  // mar_word_address[48:33], bus_phase[51:49], status_flags[56:52],
  // error_code[60:57], zero fill above
  output logic [OUT_TDATA_W-1:0] out_tdata
);

  logic                   in_valid_r;
  item_t                  item_r;
  logic                   out_valid_r;
  logic [OUT_TDATA_W-1:0] out_tdata_r;
  logic                   fire;
  logic                   accept;
  item_t                  in_item;
  logic [7:0]             rd_a, rd_b;
  result_t                result;
  reg_wr_t                reg_wr;

  assign fire = in_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !in_valid_r || fire;
  assign accept = in_tvalid && in_tready;

  always_comb begin
    in_item.a_bus_select = in_tdata[5:0];
    in_item.b_bus_select = in_tdata[11:6];
    in_item.c_dest_select = in_tdata[17:12];
    in_item.alu_function = in_tdata[22:18];
    in_item.mux_selects = in_tdata[38:23];
    in_item.mem_control = in_tdata[40:39];
    in_item.clock_enables = in_tdata[49:41];
    in_item.mem_even_byte = in_tdata[57:50];
    in_item.mem_odd_byte = in_tdata[65:58];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_tready) begin
      in_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      item_r <= in_item;
    end
  end

  mcb_regfile u_regfile (
    .clk       (clk),
    .rst_n     (rst_n),
    .rd_en     (accept),
    .rd_addr_a (in_item.a_bus_select),
    .rd_addr_b (in_item.b_bus_select),
    .wr        (reg_wr),
    .rd_data_a (rd_a),
    .rd_data_b (rd_b)
  );

  mcb_step u_step (
    .clk    (clk),
    .rst_n  (rst_n),
    .fire   (fire),
    .item   (item_r),
    .rd_a   (rd_a),
    .rd_b   (rd_b),
    .result (result),
    .reg_wr (reg_wr)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (fire) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_tdata_r <= {3'b000, result.error_code, result.status_flags, result.bus_phase,
                      result.mar_word_address, result.mem_write_word,
                      result.mem_write_address, result.mem_write_strobe};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata = out_tdata_r;

  a_stall_holds_beat: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid_r && out_valid_r && !out_tready) |=> in_valid_r)
    else $error("input beat dropped while output stalled");

  a_out_from_step: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(fire))
    else $error("result appeared without a step");

  a_no_step_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !in_valid_r |-> !reg_wr.en)
    else $error("bank written without a beat in the input register");

endmodule

>>> rtl/mcb_regfile.sv
// register bank: 22 writable bytes with registered reads, plus fixed constants
module mcb_regfile
  import mcb_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       rd_en,
  input  logic [5:0] rd_addr_a,
  input  logic [5:0] rd_addr_b,
  input  reg_wr_t    wr,
  output logic [7:0] rd_data_a,
  output logic [7:0] rd_data_b
);

  logic [7:0]             mem [NUM_WR_REGS];
  logic [NUM_WR_REGS-1:0] valid_r;
  logic [7:0]             rd_data_a_r;
  logic [7:0]             rd_data_b_r;

  function automatic logic [7:0] pick(input logic [5:0] addr, input logic [7:0] stored,
                                      input logic hit_valid);
    logic [4:0] fix_idx;
    logic [7:0] val;
    fix_idx = addr[4:0] - 5'(NUM_WR_REGS);
    val = 8'h00;
    if (addr[5]) begin
      val = 8'h00;
    end else if (addr[4:0] < 5'(NUM_WR_REGS)) begin
      if (wr.en && wr.addr == addr[4:0]) begin
        val = wr.data;
      end else if (hit_valid) begin
        val = stored;
      end
    end else begin
      val = FIXED_REGS[fix_idx[3:0]];
    end
    return val;
  endfunction

  logic [7:0] stored_a;
  logic [7:0] stored_b;
  logic       valid_a;
  logic       valid_b;

  always_comb begin
    stored_a = 8'h00;
    stored_b = 8'h00;
    valid_a = 1'b0;
    valid_b = 1'b0;
    if (!rd_addr_a[5] && rd_addr_a[4:0] < 5'(NUM_WR_REGS)) begin
      stored_a = mem[rd_addr_a[4:0]];
      valid_a = valid_r[rd_addr_a[4:0]];
    end
    if (!rd_addr_b[5] && rd_addr_b[4:0] < 5'(NUM_WR_REGS)) begin
      stored_b = mem[rd_addr_b[4:0]];
      valid_b = valid_r[rd_addr_b[4:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (wr.en && wr.addr < 5'(NUM_WR_REGS)) begin
      mem[wr.addr] <= wr.data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else if (wr.en && wr.addr < 5'(NUM_WR_REGS)) begin
      valid_r[wr.addr] <= 1'b1;
    end
  end

  // write-through so a beat taken alongside a load sees the new byte
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_a_r <= pick(rd_addr_a, stored_a, valid_a);
      rd_data_b_r <= pick(rd_addr_b, stored_b, valid_b);
    end
  end

  assign rd_data_a = rd_data_a_r;
  assign rd_data_b = rd_data_b_r;

endmodule

>>> rtl/mcb_alu.sv
// 16-function byte alu with nzvc outputs
module mcb_alu
  import mcb_pkg::*;
(
  input  logic [4:0] fn,
  input  logic       has_a,
  input  logic [7:0] a,
  input  logic       has_b,
  input  logic [7:0] b,
  input  logic       has_cs,
  input  logic       cs,
  output logic       has_res,
  output logic [7:0] res,
  output logic [3:0] nzvc
);

  logic       unary;
  logic       need_cs;
  logic [7:0] bb;
  logic       cin;
  logic [8:0] sum;
  logic [7:0] r;
  logic       c_out;
  logic       v_out;

  always_comb begin
    unary = (fn == FN_A) || (fn >= FN_NOTA);
    need_cs = 1'b0;
    bb = 8'h00;
    cin = 1'b0;
    sum = 9'h000;
    r = 8'h00;
    c_out = 1'b0;
    v_out = 1'b0;
    case (fn)
      FN_A: r = a;
      FN_ADD, FN_ADDC, FN_SUB, FN_SUBC: begin
        bb = (fn == FN_ADD || fn == FN_ADDC) ? b : ~b;
        need_cs = (fn == FN_ADDC) || (fn == FN_SUBC);
        cin = (fn == FN_SUB) ? 1'b1 : (fn == FN_ADD) ? 1'b0 : cs;
        sum = {1'b0, a} + {1'b0, bb} + {8'h00, cin};
        r = sum[7:0];
        c_out = sum[8];
        v_out = ~(a[7] ^ bb[7]) & (a[7] ^ r[7]);
      end
      FN_AND:  r = a & b;
      FN_NAND: r = ~(a & b);
      FN_OR:   r = a | b;
      FN_NOR:  r = ~(a | b);
      FN_XOR:  r = a ^ b;
      FN_NOTA: r = ~a;
      FN_ASL, FN_ROL: begin
        need_cs = (fn == FN_ROL);
        r = {a[6:0], (fn == FN_ROL) ? cs : 1'b0};
        c_out = a[7];
        v_out = a[7] ^ a[6];
      end
      FN_ASR, FN_ROR: begin
        need_cs = (fn == FN_ROR);
        r = {(fn == FN_ASR) ? a[7] : cs, a[7:1]};
        c_out = a[0];
      end
      default: r = 8'h00;
    endcase

    has_res = (fn <= FN_NZVC) && has_a && (unary || has_b) && !(need_cs && !has_cs);
    if (fn == FN_NZVC) begin
      res = 8'h00;
      nzvc = a[3:0];
    end else begin
      res = r;
      nzvc = {r[7], (r == 8'h00), v_out, c_out};
    end
  end

endmodule

>>> rtl/mcb_step.sv
// step logic: bus handshake, muxes, mar, mdr and flag registers, error codes
module mcb_step
  import mcb_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       fire,
  input  item_t      item,
  input  logic [7:0] rd_a,
  input  logic [7:0] rd_b,
  output result_t    result,
  output reg_wr_t    reg_wr
);

  phase_t      phase_r, phase_nxt;
  logic [15:0] mar_r, mar_nxt;
  logic [15:0] mdr_r, mdr_nxt;
  logic [4:0]  flags_r, flags_nxt;

  logic       has_a, has_b, mar_chg, rd_req, wr_req;
  logic [1:0] amux, csmux, cmux, marmux, mdremux, mdromux, eomux, andz;
  logic       has_amux, has_cs, has_c, cs_bit;
  logic [7:0] amux_val, c_val;
  logic       has_alu;
  logic [7:0] alu_res;
  logic [3:0] alu_nzvc;
  logic       stop_mar, stop_mdre, stop_mdro, flag_err;
  err_t       err, err_soft;

  assign has_a = !item.a_bus_select[5];
  assign has_b = !item.b_bus_select[5];
  assign rd_req = item.mem_control[0];
  assign wr_req = item.mem_control[1];
  assign amux = item.mux_selects[1:0];
  assign csmux = item.mux_selects[3:2];
  assign cmux = item.mux_selects[5:4];
  assign marmux = item.mux_selects[7:6];
  assign mdremux = item.mux_selects[9:8];
  assign mdromux = item.mux_selects[11:10];
  assign eomux = item.mux_selects[13:12];
  assign andz = item.mux_selects[15:14];

  assign mar_chg = item.clock_enables[CK_MAR] && has_a && has_b
                   && !(rd_a == mar_r[15:8] && rd_b == mar_r[7:0]);

  // memory bus handshake
  always_comb begin
    phase_nxt = phase_r;
    case (phase_r)
      PH_NONE: begin
        if (!mar_chg) begin
          if (rd_req) begin
            phase_nxt = PH_RD_WAIT1;
          end else if (wr_req) begin
            phase_nxt = PH_WR_WAIT1;
          end
        end
      end
      PH_RD_WAIT1, PH_RD_WAIT2, PH_RD_READY: begin
        if (rd_req) begin
          if (mar_chg || phase_r == PH_RD_READY) begin
            phase_nxt = PH_RD_WAIT1;
          end else if (phase_r == PH_RD_WAIT1) begin
            phase_nxt = PH_RD_WAIT2;
          end else begin
            phase_nxt = PH_RD_READY;
          end
        end else if (wr_req) begin
          phase_nxt = PH_WR_WAIT1;
        end else begin
          phase_nxt = PH_NONE;
        end
      end
      PH_WR_WAIT1, PH_WR_WAIT2, PH_WR_READY: begin
        if (wr_req) begin
          if (mar_chg || phase_r == PH_WR_READY) begin
            phase_nxt = PH_WR_WAIT1;
          end else if (phase_r == PH_WR_WAIT1) begin
            phase_nxt = PH_WR_WAIT2;
          end else begin
            phase_nxt = PH_WR_READY;
          end
        end else if (rd_req) begin
          phase_nxt = PH_RD_WAIT1;
        end else begin
          phase_nxt = PH_NONE;
        end
      end
      default: phase_nxt = PH_NONE;
    endcase
  end

  always_comb begin
    has_amux = 1'b0;
    amux_val = 8'h00;
    if (amux == MUX_SEL0) begin
      if (eomux == MUX_SEL0) begin
        amux_val = mdr_r[15:8];
        has_amux = 1'b1;
      end else if (eomux == MUX_SEL1) begin
        amux_val = mdr_r[7:0];
        has_amux = 1'b1;
      end
    end else if (amux == MUX_SEL1 && has_a) begin
      amux_val = rd_a;
      has_amux = 1'b1;
    end
    has_cs = (csmux == MUX_SEL0) || (csmux == MUX_SEL1);
    cs_bit = (csmux == MUX_SEL0) ? flags_r[FL_C] : (csmux == MUX_SEL1) ? flags_r[FL_S] : 1'b0;
  end

  mcb_alu u_alu (
    .fn      (item.alu_function),
    .has_a   (has_amux),
    .a       (amux_val),
    .has_b   (has_b),
    .b       (rd_b),
    .has_cs  (has_cs),
    .cs      (cs_bit),
    .has_res (has_alu),
    .res     (alu_res),
    .nzvc    (alu_nzvc)
  );

  always_comb begin
    has_c = 1'b0;
    c_val = 8'h00;
    if (cmux == MUX_SEL0) begin
      has_c = 1'b1;
      c_val = {4'h0, flags_r[3:0]};
    end else if (cmux == MUX_SEL1) begin
      has_c = has_alu;
      c_val = alu_res;
    end
  end

  // clocking order mar, bank, mdre, mdro, flags; some errors cut the rest off
  always_comb begin
    mar_nxt = mar_r;
    mdr_nxt = mdr_r;
    flags_nxt = flags_r;
    reg_wr = '0;
    err_soft = ERR_NONE;
    err = ERR_NONE;
    stop_mar = 1'b0;
    stop_mdre = 1'b0;
    stop_mdro = 1'b0;
    flag_err = 1'b0;

    if (item.clock_enables[CK_MAR]) begin
      if (marmux == MUX_SEL0) begin
        mar_nxt = mdr_r;
      end else if (marmux == MUX_SEL1 && has_a && has_b) begin
        mar_nxt = {rd_a, rd_b};
      end else begin
        stop_mar = 1'b1;
      end
    end

    if (!stop_mar && item.clock_enables[CK_LOAD]) begin
      if (item.c_dest_select[5]) begin
        err_soft = ERR_LOAD_DEST;
      end else if (!has_c) begin
        err_soft = ERR_LOAD_C;
      end else begin
        reg_wr.en = fire && (item.c_dest_select[4:0] < 5'(NUM_WR_REGS));
        reg_wr.addr = item.c_dest_select[4:0];
        reg_wr.data = c_val;
      end
    end

    if (!stop_mar && item.clock_enables[CK_MDRE]) begin
      if (mdremux == MUX_SEL0) begin
        if (phase_nxt != PH_RD_READY) begin
          stop_mdre = 1'b1;
          err = ERR_MDRE_MEM;
        end else begin
          mdr_nxt[15:8] = item.mem_even_byte;
        end
      end else if (mdremux == MUX_SEL1) begin
        if (!has_c) begin
          stop_mdre = 1'b1;
          err = ERR_MDRE_C;
        end else begin
          mdr_nxt[15:8] = c_val;
        end
      end else begin
        err_soft = ERR_MDRE_MUX;
      end
    end

    if (!stop_mar && !stop_mdre && item.clock_enables[CK_MDRO]) begin
      if (mdromux == MUX_SEL0) begin
        if (phase_nxt != PH_RD_READY) begin
          stop_mdro = 1'b1;
          err = ERR_MDRO_MEM;
        end else begin
          mdr_nxt[7:0] = item.mem_odd_byte;
        end
      end else if (mdromux == MUX_SEL1) begin
        if (!has_c) begin
          stop_mdro = 1'b1;
          err = ERR_MDRO_C;
        end else begin
          mdr_nxt[7:0] = c_val;
        end
      end else begin
        err_soft = ERR_MDRO_MUX;
      end
    end

    if (stop_mar || stop_mdre || stop_mdro) begin
      mdr_nxt = stop_mar ? mdr_r : mdr_nxt;
    end else begin
      if (item.clock_enables[CK_N]) begin
        if (has_alu) flags_nxt[FL_N] = alu_nzvc[3];
        else flag_err = 1'b1;
      end
      if (item.clock_enables[CK_Z]) begin
        if (has_alu && andz == MUX_SEL0) flags_nxt[FL_Z] = alu_nzvc[2];
        else if (has_alu && andz == MUX_SEL1) flags_nxt[FL_Z] = alu_nzvc[2] & flags_r[FL_Z];
        else flag_err = 1'b1;
      end
      if (item.clock_enables[CK_V]) begin
        if (has_alu) flags_nxt[FL_V] = alu_nzvc[1];
        else flag_err = 1'b1;
      end
      if (item.clock_enables[CK_C]) begin
        if (has_alu) flags_nxt[FL_C] = alu_nzvc[0];
        else flag_err = 1'b1;
      end
      if (item.clock_enables[CK_S]) begin
        if (has_alu) flags_nxt[FL_S] = alu_nzvc[0];
        else flag_err = 1'b1;
      end
      err = flag_err ? ERR_FLAG : err_soft;
    end
    if (stop_mar) begin
      err = ERR_MAR;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_NONE;
      mar_r <= '0;
      mdr_r <= '0;
      flags_r <= '0;
    end else if (fire) begin
      phase_r <= phase_nxt;
      mar_r <= mar_nxt;
      mdr_r <= mdr_nxt;
      flags_r <= flags_nxt;
    end
  end

  always_comb begin
    result.mem_write_strobe = (phase_nxt == PH_WR_READY);
    result.mem_write_address = (phase_nxt == PH_WR_READY) ? (mar_r & WORD_MASK) : 16'h0000;
    result.mem_write_word = (phase_nxt == PH_WR_READY) ? mdr_r : 16'h0000;
    result.mar_word_address = mar_nxt & WORD_MASK;
    result.bus_phase = phase_nxt;
    result.status_flags = flags_nxt;
    result.error_code = err;
  end

  a_rd_ready_path: assert property (@(posedge clk) disable iff (!rst_n)
    (fire && phase_nxt == PH_RD_READY) |->
      (phase_r == PH_RD_WAIT2 || phase_r == PH_RD_READY))
    else $error("read ready reached without two wait cycles");

  a_abort_keeps_flags: assert property (@(posedge clk) disable iff (!rst_n)
    (fire && (err == ERR_MAR || err == ERR_MDRE_MEM || err == ERR_MDRE_C
              || err == ERR_MDRO_MEM || err == ERR_MDRO_C)) |=> $stable(flags_r))
    else $error("flags changed on an aborted step");

  a_mar_abort_keeps_mar: assert property (@(posedge clk) disable iff (!rst_n)
    (fire && err == ERR_MAR) |=> ($stable(mar_r) && $stable(mdr_r)))
    else $error("mar or mdr changed after a mar error");

endmodule
